[rtl/indexed_shift_table_top_assert.svh]
// Assertion macros for the indexed shift table.
`ifndef INDEXED_SHIFT_TABLE_TOP_ASSERT_SVH
`define INDEXED_SHIFT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ist_pkg.sv]
package ist_pkg;

  // Opcode field of an input transaction.
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_CHOP   = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5
  } ist_op_e;

  // Status field of a result transaction.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } ist_status_e;

  // Update broadcast to every cell.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_CHOP,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } ist_cell_op_e;

  typedef struct packed {
    ist_cell_op_e op;
    logic         rd_en;
  } ist_cmd_t;

endpackage

[rtl/ist_cell.sv]
module ist_cell #(
  parameter int IDX       = 0,
  parameter int WORD_BITS = 32,
  parameter int CMP_W     = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ist_pkg::ist_cmd_t    cmd_i,
  input  logic [CMP_W-1:0]     pos_i,
  input  logic [CMP_W-1:0]     cnt_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [WORD_BITS-1:0] left_i,   // entry IDX-1
  input  logic [WORD_BITS-1:0] right_i,  // entry IDX+1
  output logic [WORD_BITS-1:0] value_o,
  output logic [WORD_BITS-1:0] rd_o
);
  import ist_pkg::*;

  localparam logic [CMP_W-1:0] MyIdx   = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] NextIdx = CMP_W'(IDX + 1);

  logic [WORD_BITS-1:0] val_d, val_q;

  always_comb begin
    val_d = val_q;
    unique case (cmd_i.op)
      CELL_HOLD: ;
      CELL_APPEND: begin
        if (cnt_i == MyIdx) val_d = wdata_i;
      end
      CELL_CHOP: begin
        if (cnt_i == NextIdx) val_d = '0;
      end
      CELL_INSERT: begin
        if (pos_i == MyIdx) begin
          val_d = wdata_i;
        end else if (pos_i < MyIdx && MyIdx <= cnt_i) begin
          val_d = left_i;
        end
      end
      CELL_REMOVE: begin
        // last live slot is freed, everything from pos up to it moves down
        if (cnt_i == NextIdx) begin
          val_d = '0;
        end else if (pos_i <= MyIdx && NextIdx < cnt_i) begin
          val_d = right_i;
        end
      end
      CELL_WRITE: begin
        if (pos_i == MyIdx) val_d = wdata_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign value_o = val_q;
  assign rd_o    = (cmd_i.rd_en && pos_i == MyIdx) ? val_q : '0;

endmodule

[rtl/indexed_shift_table_top.sv]
// Channel   Dir  Fields (tdata, low bit first)
// s_axis    in   opcode[2:0] position[6:3] write_value[38:7] zero[39]
// m_axis    out  status[1:0] read_value[33:2] entry_count[38:34] zero[39]
//
// For each transaction the command is decoded against the live count
// and broadcast to a row of DEPTH cells, each of which updates its entry from
// itself or a neighbor at the same edge, so insert and remove cost no more
// than read. The result lands in an output register; s_axis_tready is high
// whenever that register is empty or being drained. Reset (async, low) clears
// all entries and the count at once; no clearing pass.
module indexed_shift_table_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // opcode, position, write_value, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status, read_value, entry_count, pad
);
  import ist_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > 4) ? CntW : 4;

  // input fields
  ist_op_e              op;
  logic [3:0]           pos;
  logic [31:0]          wval;
  logic [WORD_BITS-1:0] wval_w;

  assign op     = ist_op_e'(s_axis_tdata[2:0]);
  assign pos    = s_axis_tdata[6:3];
  assign wval   = s_axis_tdata[38:7];
  assign wval_w = WORD_BITS'(wval);

  logic fire;
  logic out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  // live count
  logic [CntW-1:0] count_d, count_q;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic            is_full, is_empty, pos_oob;

  assign pos_ext  = CmpW'(pos);
  assign cnt_ext  = CmpW'(count_q);
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign pos_oob  = (pos_ext >= cnt_ext);

  ist_status_e status;
  ist_cmd_t    cmd;

  // decode against the current count; cells only move on a good transaction
  always_comb begin
    status    = ST_OK;
    cmd.op    = CELL_HOLD;
    cmd.rd_en = 1'b0;
    count_d   = count_q;
    unique case (op)
      OP_APPEND: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          cmd.op  = CELL_APPEND;
          count_d = count_q + CntW'(1);
        end
      end
      OP_CHOP: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.op  = CELL_CHOP;
          count_d = count_q - CntW'(1);
        end
      end
      OP_INSERT: begin
        // bounds before fullness
        if (pos_oob) begin
          status = ST_OOB;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_oob) begin
          status = ST_OOB;
        end else begin
          cmd.op  = CELL_REMOVE;
          count_d = count_q - CntW'(1);
        end
      end
      OP_READ: begin
        if (pos_oob) status = ST_OOB;
        else cmd.rd_en = 1'b1;
      end
      OP_WRITE: begin
        if (pos_oob) status = ST_OOB;
        else cmd.op = CELL_WRITE;
      end
      default: ;  // unused opcodes: no effect, status ok
    endcase
    if (!fire) begin
      cmd.op  = CELL_HOLD;
      count_d = count_q;
    end
  end

  // row of cells, each linked to its neighbors; the end cells see zero beyond the row
  logic [WORD_BITS-1:0] vals [DEPTH];
  logic [WORD_BITS-1:0] rds  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = vals[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = vals[k+1];
    end

    ist_cell #(
      .IDX      (k),
      .WORD_BITS(WORD_BITS),
      .CMP_W    (CmpW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .pos_i  (pos_ext),
      .cnt_i  (cnt_ext),
      .wdata_i(wval_w),
      .left_i (left),
      .right_i(right),
      .value_o(vals[k]),
      .rd_o   (rds[k])
    );
  end

  // at most one cell drives a nonzero read word
  logic [WORD_BITS-1:0] rd_w;
  always_comb begin
    rd_w = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_w = rd_w | rds[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // output register
  logic [39:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {1'b0, 5'(count_d), 32'(rd_w), status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // check terms
  logic            append_ok;
  logic            out_failed;
  logic [CntW-1:0] count_inc;

  assign append_ok  = fire && op == OP_APPEND && status == ST_OK;
  assign out_failed = m_axis_tvalid && m_axis_tdata[1:0] != ST_OK;
  assign count_inc  = count_q + CntW'(1);

`include "indexed_shift_table_top_assert.svh"

  `IST_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(DEPTH), "count past depth")
  `IST_ASSERT_NEXT(a_count_hold, !fire, $stable(count_q), "count moved without a transaction")
  `IST_ASSERT_NEXT(a_append_grows, append_ok, count_q == $past(count_inc), "count did not grow")
  `IST_ASSERT_NOW(a_rd_zero, out_failed, m_axis_tdata[33:2] == '0, "read word set on failure")

endmodule
